[src/tlru_pkg.sv]
// ----------------------------------------------------------------------------
// tlru_pkg
// Shared constants for the true-LRU age replacement block: default geometry,
// transaction field widths and operation codes.
// ----------------------------------------------------------------------------
package tlru_pkg;

    localparam int DEF_SETS  = 2048;
    localparam int DEF_WAYS  = 16;

    localparam int SET_IDX_W = 11;
    localparam int WAY_IDX_W = 4;
    localparam int VICTIM_W  = 4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

endpackage

[src/tlru_age_ram.sv]
// ----------------------------------------------------------------------------
// tlru_age_ram
// Age memory: one row of packed way ages per set, one write port and one
// read port, read data registered.
// ----------------------------------------------------------------------------
module tlru_age_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int ROW_W  = 64
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ROW_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/tlru_row_logic.sv]
// ----------------------------------------------------------------------------
// tlru_row_logic
// Per-row datapath: ages every way younger than the touched way in parallel,
// and finds the oldest way through a compare tree (lowest way wins a tie).
// ----------------------------------------------------------------------------
module tlru_row_logic import tlru_pkg::*; #(
    parameter int WAYS  = 16,
    parameter int AGE_W = 4
) (
    input  logic [WAYS*AGE_W-1:0] row_in,
    input  logic [WAY_IDX_W-1:0]  way,
    output logic [WAYS*AGE_W-1:0] row_out,
    output logic [VICTIM_W-1:0]   victim
);

    localparam int WAY_W = $clog2(WAYS);
    localparam int N     = 1 << WAY_W;

    logic [WAYS-1:0][AGE_W-1:0] ages;
    logic [WAYS-1:0][AGE_W-1:0] ages_new;
    logic [AGE_W-1:0]           lim;
    logic [WAY_W-1:0]           sel;

    logic [AGE_W-1:0] t_age [0:WAY_W][0:N-1];
    logic [WAY_W-1:0] t_idx [0:WAY_W][0:N-1];

    assign ages    = row_in;
    assign sel     = WAY_W'(way);
    assign lim     = ages[sel];
    assign row_out = ages_new;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            if (WAY_W'(i) == sel)
            begin
                ages_new[i] = '0;
            end
            else if (ages[i] < lim)
            begin
                ages_new[i] = ages[i] + 1'b1;
            end
            else
            begin
                ages_new[i] = ages[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            t_age[0][i] = (i < WAYS) ? ages[i] : '0;
            t_idx[0][i] = WAY_W'(i);
        end
        for (int l = 0; l < WAY_W; l++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (i < (N >> (l + 1)))
                begin
                    if (t_age[l][2*i+1] > t_age[l][2*i])
                    begin
                        t_age[l+1][i] = t_age[l][2*i+1];
                        t_idx[l+1][i] = t_idx[l][2*i+1];
                    end
                    else
                    begin
                        t_age[l+1][i] = t_age[l][2*i];
                        t_idx[l+1][i] = t_idx[l][2*i];
                    end
                end
                else
                begin
                    t_age[l+1][i] = '0;
                    t_idx[l+1][i] = '0;
                end
            end
        end
    end

    assign victim = VICTIM_W'(t_idx[WAY_W][0]);

endmodule

[src/true_lru_age_replacement.sv]
// ----------------------------------------------------------------------------
// true_lru_age_replacement
// True-LRU replacement state with one age counter per way, kept in a set
// memory; access updates age the set, victim queries return the oldest way.
// ----------------------------------------------------------------------------
// After reset the block sweeps the age memory, one set per cycle, with busy
// high. Then a transaction is taken whenever start is high and busy is low;
// busy stays high in the cycle after acceptance, in which the set row read
// from the memory is updated and written back in the single read-modify-write
// pass through the memory port. A victim query raises done for exactly one
// cycle, the cycle after that pass, with victim_way valid; the receiver must
// take it then. Updates produce no result. A set outside SETS leaves the ages
// alone and makes a query report way 0.
module true_lru_age_replacement import tlru_pkg::*; #(
    parameter int SETS = DEF_SETS,
    parameter int WAYS = DEF_WAYS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 operation,
    input  logic [SET_IDX_W-1:0] set_index,
    input  logic [WAY_IDX_W-1:0] way_index,
    input  logic                 was_hit,
    input  logic                 is_writeback,
    output logic                 done,
    output logic [VICTIM_W-1:0]  victim_way
);

    localparam int ADDR_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AGE_W  = $clog2(WAYS);
    localparam int ROW_W  = WAYS * AGE_W;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                op_reg;
    logic                set_ok_reg;
    logic                upd_en_reg;
    logic [WAY_IDX_W-1:0] way_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                done_reg;
    logic [VICTIM_W-1:0] victim_reg;

    logic                accept;
    logic                set_ok;
    logic                way_ok;
    logic                clear_last;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic [ROW_W-1:0]    ram_rdata;
    logic [ROW_W-1:0]    row_upd;
    logic [ROW_W-1:0]    row_fill;
    logic [VICTIM_W-1:0] victim;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign set_ok     = int'(set_index) < SETS;
    assign way_ok     = int'(way_index) < WAYS;
    assign clear_last = int'(clr_cnt_reg) == (SETS - 1);
    assign row_fill   = {WAYS{AGE_W'(WAYS - 1)}};

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= (state_reg == S_EXEC) && (op_reg == OP_QUERY);
        end
    end

    // hold the accepted transaction for the write-back cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            set_ok_reg <= set_ok;
            upd_en_reg <= (operation == OP_UPDATE) && !(was_hit && is_writeback)
                          && set_ok && way_ok;
            way_reg    <= way_index;
            addr_reg   <= ADDR_W'(set_index);
        end
        if (state_reg == S_EXEC)
        begin
            victim_reg <= set_ok_reg ? victim : '0;
        end
    end

    assign ram_we    = (state_reg == S_CLEAR) || ((state_reg == S_EXEC) && upd_en_reg);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? row_fill : row_upd;

    tlru_age_ram #(
        .DEPTH  (SETS),
        .ADDR_W (ADDR_W),
        .ROW_W  (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ADDR_W'(set_index)),
        .rdata (ram_rdata)
    );

    tlru_row_logic #(
        .WAYS  (WAYS),
        .AGE_W (AGE_W)
    ) u_row (
        .row_in  (ram_rdata),
        .way     (way_reg),
        .row_out (row_upd),
        .victim  (victim)
    );

    assign done       = done_reg;
    assign victim_way = victim_reg;

    a_done_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC && op_reg == OP_QUERY))
        else $error("done without a query in the write-back cycle");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not advance to write-back");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_EXEC))
        else $error("age memory written outside clear or write-back");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(set_ok_reg) || victim_reg == '0))
        else $error("out-of-range set reported a nonzero victim");

endmodule
